>>> design/stg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

  localparam int unsigned SAMPLE_RATE_DEF      = 44100;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

  localparam int unsigned FREQ_W     = 15;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned VOL_W      = 7;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned COUNT_W    = 22;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned FRAC_W     = 30;
  localparam int unsigned PROD_W     = 2 * AMP_W;
  localparam int unsigned AMP_DIV_W  = 22;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ = 2'd0,
    CFG_DUR  = 2'd1,
    CFG_VOL  = 2'd2
  } cfg_reg_e;

  localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(1000);
  localparam logic [DUR_W-1:0]  DUR_RST  = DUR_W'(100);
  localparam logic [VOL_W-1:0]  VOL_RST  = VOL_W'(50);
  localparam logic [VOL_W-1:0]  VOL_MAX  = VOL_W'(100);

  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned PCT_SCALE = 100;

  localparam logic [AMP_W-1:0]   FULL_SCALE = AMP_W'(32767);
  localparam logic [COUNT_W-1:0] COUNT_IDLE = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'((64'd1 << COUNT_W) - 64'd2);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // floor(p / 32767) for p < 2^30 as (p * RECIP) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 45;
  localparam int unsigned RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd32766) / 64'd32767);

endpackage

`default_nettype wire

>>> design/stg_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stg_cfg_if;
  import stg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/stg_tick_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stg_tick_if;
  import stg_pkg::*;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

>>> design/stg_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stg_sample_if;
  import stg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       last;

  modport source (output valid, output left_sample, output right_sample, output last,
                  input ready);
  modport sink   (input valid, input left_sample, input right_sample, input last,
                  output ready);
endinterface

`default_nettype wire

>>> design/stg_cdiv.sv
`timescale 1ns / 1ps
`default_nettype none

// quotient by a constant as a reciprocal multiply, 16 dividend bits a cycle
module stg_cdiv #(
  parameter int unsigned DIVIDEND_W = 47,
  parameter int unsigned QUOT_W     = 32,
  parameter int unsigned DIVISOR    = stg_pkg::SAMPLE_RATE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic [QUOT_W-1:0]     quot_o,
  output logic                  busy_o
);
  import stg_pkg::*;

  localparam int unsigned DIV_W   = $clog2(DIVISOR);
  localparam int unsigned SHIFT   = DIVIDEND_W + DIV_W;
  localparam int unsigned RCP_W   = DIVIDEND_W + 1;
  localparam logic [127:0] RCP_WIDE =
    ((128'd1 << SHIFT) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_WIDE);

  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned N_CHUNK = (DIVIDEND_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PAD_W   = N_CHUNK * CHUNK_W;
  localparam int unsigned ACC_W   = DIVIDEND_W + RCP_W;
  localparam int unsigned PART_W  = CHUNK_W + RCP_W;
  localparam int unsigned CNT_W   = $clog2(N_CHUNK + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PAD_W-1:0]  num_q;
  logic [ACC_W-1:0]  acc_q;
  logic [PART_W-1:0] part;
  logic [ACC_W-1:0]  acc_next;

  // top chunk first, accumulate horner style
  assign part     = PART_W'(num_q[PAD_W-1 -: CHUNK_W]) * PART_W'(RCP);
  assign acc_next = (acc_q << CHUNK_W) + ACC_W'(part);

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(N_CHUNK);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= PAD_W'(dividend_i);
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= num_q << CHUNK_W;
      acc_q <= acc_next;
    end
  end

  assign quot_o = QUOT_W'(acc_q >> SHIFT);
  assign busy_o = cnt_q != '0;

endmodule

`default_nettype wire

>>> design/sine_tone_generator.sv
// channel   dir  word                                   handshake
// cfg_i     in   index, data (register write)           valid/ready, ready always high
// tick_i    in   restart                                valid/ready
// sample_o  out  left_sample, right_sample, last        valid/ready
//
// one tick per cycle while ready; each sample then passes rom read, scale, divide
// reset and each register write hold tick_i.ready low while step,
// tone length and amplitude are rebuilt by reciprocal multiplies, 16 dividend bits a cycle
// ticks past the end of a tone are taken and give no word
// a stalled sample_o fills the 3 inner stages before tick_i.ready drops
`timescale 1ns / 1ps
`default_nettype none

module sine_tone_generator #(
  parameter int unsigned SAMPLE_RATE      = stg_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = stg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  stg_cfg_if.sink       cfg_i,
  stg_tick_if.sink      tick_i,
  stg_sample_if.source  sample_o
);
  import stg_pkg::*;

  localparam int unsigned ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDX_PROD_W = FRAC_W + ADDR_W;
  localparam int unsigned DUR_PROD_W = DUR_W + $clog2(SAMPLE_RATE + 1);
  localparam int unsigned STEP_DIV_W = FREQ_W + PHASE_W;
  localparam int unsigned MAG_PROD_W = PROD_W + RECIP_W;

  typedef logic [AMP_W-1:0] rom_t [SINE_TABLE_DEPTH+1];

  function automatic logic [AMP_W-1:0] quarter_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        scaled;
    logic signed [63:0] sum;
    begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      scaled = ((unsigned'(sum) * 64'(FULL_SCALE)) + (64'd1 << 29)) >> 30;
      if (scaled > 64'(FULL_SCALE)) begin
        scaled = 64'(FULL_SCALE);
      end
      return scaled[AMP_W-1:0];
    end
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    begin
      for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
        rom[k] = quarter_entry(k);
      end
      return rom;
    end
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration registers and derived constants
  logic [FREQ_W-1:0]     freq_q;
  logic [DUR_W-1:0]      dur_q;
  logic [VOL_W-1:0]      vol_q;
  logic                  start_q;
  logic                  cfg_fire;
  logic [VOL_W-1:0]      vol_clamp;
  logic [PHASE_W-1:0]    step;
  logic [DUR_PROD_W-1:0] total_raw;
  logic [AMP_W-1:0]      amp;
  logic [COUNT_W-1:0]    total;
  logic                  busy_step, busy_total, busy_amp, cfg_busy;

  assign cfg_fire    = cfg_i.valid & cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= FREQ_RST;
      dur_q   <= DUR_RST;
      vol_q   <= VOL_RST;
      start_q <= 1'b1;
    end else begin
      start_q <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_FREQ: freq_q <= cfg_i.data[FREQ_W-1:0];
          CFG_DUR:  dur_q  <= cfg_i.data[DUR_W-1:0];
          CFG_VOL:  vol_q  <= cfg_i.data[VOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign vol_clamp = (vol_q > VOL_MAX) ? VOL_MAX : vol_q;

  stg_cdiv #(
    .DIVIDEND_W (STEP_DIV_W),
    .QUOT_W     (PHASE_W),
    .DIVISOR    (SAMPLE_RATE)
  ) u_step_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i ({freq_q, {PHASE_W{1'b0}}}),
    .quot_o     (step),
    .busy_o     (busy_step)
  );

  stg_cdiv #(
    .DIVIDEND_W (DUR_PROD_W),
    .QUOT_W     (DUR_PROD_W),
    .DIVISOR    (MS_PER_S)
  ) u_total_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (DUR_PROD_W'(dur_q) * DUR_PROD_W'(SAMPLE_RATE)),
    .quot_o     (total_raw),
    .busy_o     (busy_total)
  );

  stg_cdiv #(
    .DIVIDEND_W (AMP_DIV_W),
    .QUOT_W     (AMP_W),
    .DIVISOR    (PCT_SCALE)
  ) u_amp_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (AMP_DIV_W'(vol_clamp) * AMP_DIV_W'(FULL_SCALE)),
    .quot_o     (amp),
    .busy_o     (busy_amp)
  );

  assign cfg_busy = start_q | busy_step | busy_total | busy_amp;
  assign total    = (total_raw > DUR_PROD_W'(COUNT_MAX)) ? COUNT_MAX
                                                         : total_raw[COUNT_W-1:0];

  // tone state
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [PHASE_W-1:0] phase_eff;
  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] count_inc;
  logic               hit;
  logic               tick_fire;

  // pipeline
  logic                  s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic                  s1_en, s2_en, s3_en, out_en;
  logic [PHASE_W-1:0]    s1_phase_q;
  logic                  s1_last_q;
  logic [AMP_W-1:0]      s2_rom_q;
  logic                  s2_neg_q, s2_last_q;
  logic [PROD_W-1:0]     s3_prod_q;
  logic                  s3_neg_q, s3_last_q;
  logic [SAMPLE_W-1:0]   sample_q;
  logic                  last_q;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [ADDR_W-1:0]     idx;
  logic [ADDR_W-1:0]     rom_addr;
  logic [MAG_PROD_W-1:0] mag_prod;
  logic [SAMPLE_W-1:0]   mag;

  assign out_en = ~out_v_q | sample_o.ready;
  assign s3_en  = ~s3_v_q | out_en;
  assign s2_en  = ~s2_v_q | s3_en;
  assign s1_en  = ~s1_v_q | s2_en;

  assign tick_i.ready = s1_en & ~cfg_busy;
  assign tick_fire    = tick_i.valid & tick_i.ready;

  assign phase_eff = tick_i.restart ? '0 : phase_q;
  assign count_eff = tick_i.restart ? '0 : count_q;
  assign count_inc = count_eff + COUNT_W'(1);
  assign hit       = count_eff < total;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (tick_fire) begin
      phase_d = hit ? phase_eff + step : phase_eff;
      count_d = hit ? count_inc : count_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= COUNT_IDLE;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      if (s1_en) begin
        s1_v_q <= tick_fire & hit;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
      if (out_en) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  // quarter-wave address: mirrored in quadrants 1 and 3
  assign idx_prod = IDX_PROD_W'(s1_phase_q[FRAC_W-1:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[FRAC_W +: ADDR_W];
  assign rom_addr = s1_phase_q[FRAC_W] ? ADDR_W'(SINE_TABLE_DEPTH) - idx : idx;

  assign mag_prod = MAG_PROD_W'(s3_prod_q) * MAG_PROD_W'(RECIP);
  assign mag      = SAMPLE_W'(mag_prod[RECIP_SHIFT +: AMP_W]);

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_phase_q <= phase_eff;
      s1_last_q  <= count_inc == total;
    end
    if (s2_en) begin
      s2_rom_q  <= SINE_ROM[rom_addr];
      s2_neg_q  <= s1_phase_q[FRAC_W+1];
      s2_last_q <= s1_last_q;
    end
    if (s3_en) begin
      s3_prod_q <= PROD_W'(s2_rom_q) * PROD_W'(amp);
      s3_neg_q  <= s2_neg_q;
      s3_last_q <= s2_last_q;
    end
    if (out_en) begin
      sample_q <= s3_neg_q ? -mag : mag;
      last_q   <= s3_last_q;
    end
  end

  assign sample_o.valid        = out_v_q;
  assign sample_o.left_sample  = sample_q;
  assign sample_o.right_sample = sample_q;
  assign sample_o.last         = last_q;

endmodule

`default_nettype wire
